// ===== src/running_median_two_heaps_assert.svh =====
// Assertion macros for the running median block.
// Used by the datapath; needs nothing else.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH

// same-cycle implication
`define RMTH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmth assertion failed");

// next-cycle implication
`define RMTH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmth assertion failed");

`endif

// ===== src/rmth_pkg.sv =====
// Shared types, constants and helpers of the running median block.
// No dependencies.
package rmth_pkg;

   localparam int RMTH_CAPACITY = 1024;
   localparam int RMTH_DATA_W   = 32;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_PUSH, ST_UP_RD, ST_UP_CMP, ST_BAL,
      ST_POP_RT, ST_POP_RL, ST_POP_SET, ST_DN_RL, ST_DN_RR, ST_DN_CMP,
      ST_FIN, ST_MED_RD, ST_EMIT, ST_OVF
   } state_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_PUSH, OP_UP_RD, OP_UP_CMP, OP_POP_RT, OP_POP_RL,
      OP_POP_SET, OP_DN_RL, OP_DN_RR, OP_DN_CMP, OP_MED_RD, OP_EMIT_MED,
      OP_EMIT_OVF
   } op_type;

   // heap select: lower is the max-heap, upper the min-heap
   localparam logic HEAP_LOWER = 1'b0;
   localparam logic HEAP_UPPER = 1'b1;

   typedef struct packed {
      op_type op;
      logic   sel;   // heap worked on
      logic   src;   // push value: 0 sample, 1 popped top
   } cmd_type;

   typedef struct packed {
      logic full;
      logic to_lower;
      logic idx_zero;
      logic up_stop;
      logic dn_stop;
      logic need_up;
      logic need_low;
      logic odd;
      logic out_free;
   } status_type;

   // heap order: true if a belongs above b
   function automatic logic ranks_above(input logic signed [RMTH_DATA_W-1:0] a,
                                        input logic signed [RMTH_DATA_W-1:0] b,
                                        input logic sel);
      ranks_above = (sel == HEAP_LOWER) ? (a > b) : (a < b);
   endfunction

endpackage

// ===== src/running_median_two_heaps.sv =====
// Running median over two heaps, one input word at a time; the next word waits.
// Per word: accept, check, push with a read/compare sift-up step per level, at most
// one pop from the fuller heap (read top, read last, set, then per level read left,
// read right, compare) pushed into the other, then, for an odd count, the median word.
// Overflow answers, no push; a stalled result port holds the sequencer. Synchronous
// reset clears counts and median (no clearing pass); heap RAM contents are left as is.
module running_median_two_heaps import rmth_pkg::*; #(
   parameter int CAPACITY = RMTH_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   input  logic        req_tuser,   // [0] first
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] median
   output logic        rsp_tuser    // [0] overflow
);
   cmd_type    cmd;
   status_type status;

   rmth_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .status(status), .cmd(cmd)
   );

   rmth_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_sample(req_tdata), .req_first(req_tuser),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_median(rsp_tdata), .rsp_overflow(rsp_tuser)
   );
endmodule

// ===== src/rmth_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
module rmth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 514
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== src/rmth_ctrl.sv =====
// Sequencer of the running median block: drives datapath operations.
// Depends on rmth_pkg.
module rmth_ctrl import rmth_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;
   logic      sel_ff, sel_in;
   logic      src_ff, src_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= HEAP_UPPER;
         src_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         src_ff   <= src_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      src_in   = src_ff;
      case (state_ff)
         ST_IDLE:    if (req_tvalid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.full) begin
               state_in = ST_OVF;
            end else begin
               state_in = ST_PUSH;
               sel_in   = status.to_lower ? HEAP_LOWER : HEAP_UPPER;
               src_in   = 1'b0;
            end
         end
         ST_OVF:     if (status.out_free) state_in = ST_IDLE;
         ST_PUSH:    state_in = ST_UP_RD;
         ST_UP_RD:   state_in = status.idx_zero ? ST_BAL : ST_UP_CMP;
         ST_UP_CMP:  state_in = status.up_stop ? ST_BAL : ST_UP_RD;
         ST_BAL: begin
            if (status.need_up) begin
               state_in = ST_POP_RT;
               sel_in   = HEAP_UPPER;
            end else if (status.need_low) begin
               state_in = ST_POP_RT;
               sel_in   = HEAP_LOWER;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_POP_RT:  state_in = ST_POP_RL;
         ST_POP_RL:  state_in = ST_POP_SET;
         ST_POP_SET: state_in = ST_DN_RL;
         ST_DN_RL:   state_in = ST_DN_RR;
         ST_DN_RR:   state_in = ST_DN_CMP;
         ST_DN_CMP: begin
            if (status.dn_stop) begin
               state_in = ST_PUSH;
               sel_in   = ~sel_ff;
               src_in   = 1'b1;
            end else begin
               state_in = ST_DN_RL;
            end
         end
         ST_FIN: begin
            if (!status.odd) state_in = ST_IDLE;
            else if (status.out_free) state_in = ST_MED_RD;
         end
         ST_MED_RD:  state_in = ST_EMIT;
         ST_EMIT:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.sel    = sel_ff;
      cmd.src    = src_ff;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = OP_LOAD;
         end
         ST_OVF:     if (status.out_free) cmd.op = OP_EMIT_OVF;
         ST_PUSH:    cmd.op = OP_PUSH;
         ST_UP_RD:   cmd.op = OP_UP_RD;
         ST_UP_CMP:  cmd.op = OP_UP_CMP;
         ST_POP_RT:  cmd.op = OP_POP_RT;
         ST_POP_RL:  cmd.op = OP_POP_RL;
         ST_POP_SET: cmd.op = OP_POP_SET;
         ST_DN_RL:   cmd.op = OP_DN_RL;
         ST_DN_RR:   cmd.op = OP_DN_RR;
         ST_DN_CMP:  cmd.op = OP_DN_CMP;
         ST_MED_RD: begin
            cmd.op  = OP_MED_RD;
            cmd.sel = HEAP_UPPER;
         end
         ST_EMIT: begin
            cmd.op  = OP_EMIT_MED;
            cmd.sel = HEAP_UPPER;
         end
         default:    cmd.op = OP_NONE;
      endcase
   end
endmodule

// ===== src/rmth_dp.sv =====
// Datapath of the running median block: counts, sift registers, heap RAMs,
// output word register. Depends on rmth_pkg, rmth_ram and the assert header.
`include "running_median_two_heaps_assert.svh"
module rmth_dp import rmth_pkg::*; #(
   parameter int CAPACITY = RMTH_CAPACITY
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [RMTH_DATA_W-1:0] req_sample,
   input  logic                   req_first,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [RMTH_DATA_W-1:0] rsp_median,
   output logic                   rsp_overflow
);
   localparam int SLOTS = CAPACITY / 2 + 2;
   localparam int AW    = $clog2(SLOTS);
   localparam int TW    = $clog2(CAPACITY + 1) + 1;
   localparam logic [TW-1:0] CAP_T = TW'(CAPACITY);

   typedef logic signed [RMTH_DATA_W-1:0] word_type;

   logic [AW-1:0] lo_cnt_ff, lo_cnt_in, up_cnt_ff, up_cnt_in;
   word_type      med_ff, med_in;
   word_type      sample_ff, sample_in;
   word_type      val_ff, val_in, top_ff, top_in, bval_ff, bval_in;
   logic [AW-1:0] idx_ff, idx_in, n_ff, n_in, bidx_ff, bidx_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_ovf_ff, rsp_ovf_in;
   word_type      rsp_med_ff, rsp_med_in;

   logic [AW-1:0]          raddr, waddr, parent, cnt_sel, fin_idx;
   logic [AW:0]            lchild, rchild;
   logic                   we, has_l, has_r;
   word_type               wdata, rd, lo_rd, up_rd, fin_val;
   logic [TW-1:0]          total;

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_cnt_ff    <= '0;
         up_cnt_ff    <= '0;
         med_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lo_cnt_ff    <= lo_cnt_in;
         up_cnt_ff    <= up_cnt_in;
         med_ff       <= med_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      val_ff     <= val_in;
      top_ff     <= top_in;
      bval_ff    <= bval_in;
      idx_ff     <= idx_in;
      n_ff       <= n_in;
      bidx_ff    <= bidx_in;
      rsp_ovf_ff <= rsp_ovf_in;
      rsp_med_ff <= rsp_med_in;
   end

   // heap address arithmetic
   assign total   = TW'(lo_cnt_ff) + TW'(up_cnt_ff);
   assign cnt_sel = (cmd.sel == HEAP_UPPER) ? up_cnt_ff : lo_cnt_ff;
   assign rd      = (cmd.sel == HEAP_UPPER) ? up_rd : lo_rd;
   assign parent  = (idx_ff - AW'(1)) >> 1;
   assign lchild  = {idx_ff, 1'b1};
   assign rchild  = lchild + (AW+1)'(1);
   assign has_l   = lchild < (AW+1)'(n_ff);
   assign has_r   = rchild < (AW+1)'(n_ff);

   // best of three at the end of a sift-down step
   always_comb begin
      if (has_r && ranks_above(rd, bval_ff, cmd.sel)) begin
         fin_val = rd;
         fin_idx = rchild[AW-1:0];
      end else begin
         fin_val = bval_ff;
         fin_idx = bidx_ff;
      end
   end

   always_comb begin
      lo_cnt_in    = lo_cnt_ff;
      up_cnt_in    = up_cnt_ff;
      med_in       = med_ff;
      sample_in    = sample_ff;
      val_in       = val_ff;
      top_in       = top_ff;
      bval_in      = bval_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      bidx_in      = bidx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_med_in   = rsp_med_ff;
      raddr        = '0;
      waddr        = idx_ff;
      wdata        = val_ff;
      we           = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (cmd.op)
         OP_LOAD: begin
            sample_in = req_sample;
            if (req_first) begin
               lo_cnt_in = '0;
               up_cnt_in = '0;
               med_in    = '0;
            end
         end
         OP_PUSH: begin
            idx_in = cnt_sel;
            val_in = cmd.src ? top_ff : sample_ff;
            if (cmd.sel == HEAP_UPPER) up_cnt_in = up_cnt_ff + AW'(1);
            else lo_cnt_in = lo_cnt_ff + AW'(1);
         end
         OP_UP_RD: begin
            raddr = parent;
            if (idx_ff == '0) we = 1'b1;
         end
         OP_UP_CMP: begin
            we = 1'b1;
            if (ranks_above(val_ff, rd, cmd.sel)) begin
               wdata  = rd;
               idx_in = parent;
            end
         end
         OP_POP_RT: begin
            raddr = '0;
            n_in  = cnt_sel - AW'(1);
            if (cmd.sel == HEAP_UPPER) up_cnt_in = up_cnt_ff - AW'(1);
            else lo_cnt_in = lo_cnt_ff - AW'(1);
         end
         OP_POP_RL: begin
            raddr  = n_ff;
            top_in = rd;
         end
         OP_POP_SET: begin
            val_in = rd;
            idx_in = '0;
         end
         OP_DN_RL:  raddr = lchild[AW-1:0];
         OP_DN_RR: begin
            raddr = rchild[AW-1:0];
            if (has_l && ranks_above(rd, val_ff, cmd.sel)) begin
               bval_in = rd;
               bidx_in = lchild[AW-1:0];
            end else begin
               bval_in = val_ff;
               bidx_in = idx_ff;
            end
         end
         OP_DN_CMP: begin
            we = 1'b1;
            if (fin_idx != idx_ff) begin
               wdata  = fin_val;
               idx_in = fin_idx;
            end
         end
         OP_MED_RD: raddr = '0;
         OP_EMIT_MED: begin
            med_in       = rd;
            rsp_valid_in = 1'b1;
            rsp_med_in   = rd;
            rsp_ovf_in   = 1'b0;
         end
         OP_EMIT_OVF: begin
            rsp_valid_in = 1'b1;
            rsp_med_in   = '0;
            rsp_ovf_in   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // heap storage
   rmth_ram #(.WIDTH(RMTH_DATA_W), .DEPTH(SLOTS)) u_lower (
      .clock(clock), .we(we && (cmd.sel == HEAP_LOWER)), .waddr(waddr),
      .wdata(wdata), .raddr(raddr), .rdata(lo_rd)
   );
   rmth_ram #(.WIDTH(RMTH_DATA_W), .DEPTH(SLOTS)) u_upper (
      .clock(clock), .we(we && (cmd.sel == HEAP_UPPER)), .waddr(waddr),
      .wdata(wdata), .raddr(raddr), .rdata(up_rd)
   );

   // status to the sequencer
   assign status.full     = total >= CAP_T;
   assign status.to_lower = sample_ff < med_ff;
   assign status.idx_zero = idx_ff == '0;
   assign status.up_stop  = !ranks_above(val_ff, rd, cmd.sel);
   assign status.dn_stop  = fin_idx == idx_ff;
   assign status.need_up  = (TW'(up_cnt_ff)) > (TW'(lo_cnt_ff) + TW'(1));
   assign status.need_low = lo_cnt_ff > up_cnt_ff;
   assign status.odd      = total[0];
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_median   = rsp_med_ff;
   assign rsp_overflow = rsp_ovf_ff;

   `RMTH_ASSERT_NOW(a_balanced, clock, reset, cmd.op == OP_LOAD,
      (up_cnt_ff == lo_cnt_ff) || (up_cnt_ff == lo_cnt_ff + AW'(1)))
   `RMTH_ASSERT_NOW(a_total_cap, clock, reset, 1'b1, total <= CAP_T)
   `RMTH_ASSERT_NEXT(a_emit_valid, clock, reset,
      (cmd.op == OP_EMIT_MED) || (cmd.op == OP_EMIT_OVF), rsp_valid_ff)
endmodule

// ===== bench/tb_running_median_two_heaps.sv =====
// Testbench for the two-heap running median: directed table, overflow fill, random runs.
// Depends on rmth_pkg and running_median_two_heaps.
module tb_running_median_two_heaps;
   import rmth_pkg::*;

   typedef struct {
      logic [31:0] sample;
      logic        first;
      logic        chk;      // typed-in expectation present
      logic [31:0] med;
      logic        ovf;
   } stim_row_type;

   typedef struct {
      logic [31:0] median;
      logic        overflow;
   } median_word_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   running_median_two_heaps dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state: both halves kept as sorted queues
   int signed       low_half[$];   // ascending; top is last
   int signed       high_half[$];  // ascending; top is first
   int signed       prev_median;
   median_word_type medians_due[$];
   median_word_type last_word;
   int              words_queued = 0;
   int              errors = 0;
   int              cycles = 0;
   logic            quiet = 0;     // no idling stretch

   function automatic void sorted_put(ref int signed q[$], input int signed v);
      int k;
      k = 0;
      while (k < q.size() && q[k] <= v) k++;
      q.insert(k, v);
   endfunction

   // append one expected word
   function automatic void queue_word(input median_word_type w);
      medians_due.insert(medians_due.size(), w);
      last_word = w;
      words_queued++;
   endfunction

   // apply one sample to the model, queue any median word it causes
   function automatic void predict_median(input logic [31:0] s, input logic f);
      int signed v;
      int signed m;
      median_word_type w;
      v = s;
      if (f) begin
         low_half.delete();
         high_half.delete();
         prev_median = 0;
      end
      if (low_half.size() + high_half.size() >= RMTH_CAPACITY) begin
         w.median = '0;
         w.overflow = 1'b1;
         queue_word(w);
         return;
      end
      if (v < prev_median) sorted_put(low_half, v);
      else sorted_put(high_half, v);
      while (high_half.size() > low_half.size() + 1) begin
         m = high_half.pop_front();
         sorted_put(low_half, m);
      end
      while (low_half.size() > high_half.size()) begin
         m = low_half.pop_back();
         sorted_put(high_half, m);
      end
      if (((low_half.size() + high_half.size()) & 1) == 0) return;
      prev_median = high_half[0];
      w.median = prev_median;
      w.overflow = 1'b0;
      queue_word(w);
   endfunction

   // drive one word; returns at the edge that accepts it, valid still high
   task automatic send_word(input logic [31:0] s, input logic f);
      while (!quiet && $urandom_range(99) < 7) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= s;
      req_tuser <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_median(s, f);
   endtask

   function automatic logic [31:0] rand_sample();
      case ($urandom_range(5))
         0: return 32'h8000_0000 | $urandom_range(3);
         1: return 32'h7fff_fffc | $urandom_range(3);
         2: return $urandom_range(20) - 10;
         default: return $urandom;
      endcase
   endfunction

   // result side: stall at random, check each word against the oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (medians_due.size() == 0) begin
               $error("unexpected result word median=%0d", $signed(rsp_tdata));
               errors++;
            end else begin
               median_word_type w;
               w = medians_due.pop_front();
               if (rsp_tdata !== w.median) begin
                  $error("median exp %0d got %0d", $signed(w.median), $signed(rsp_tdata));
                  errors++;
               end
               if (rsp_tuser !== w.overflow) begin
                  $error("overflow exp %0b got %0b", w.overflow, rsp_tuser);
                  errors++;
               end
            end
         end
         rsp_tready <= quiet || ($urandom_range(99) >= 7);
      end
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > 900000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   stim_row_type table_rows[15];

   initial begin
      stim_row_type r;
      int n;
      int seq_len;
      int len;
      int k;
      prev_median = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed rows; expectation typed in only where obvious
      table_rows = '{
         '{32'd5, 1'b0, 1'b1, 32'd5, 1'b0},                   // no first after reset
         '{32'd3, 1'b0, 1'b0, 32'd0, 1'b0},                   // even count, no word
         '{32'd9, 1'b0, 1'b0, 32'd0, 1'b0},
         '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b0},   // most negative alone
         '{32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff, 1'b0},   // most positive alone
         '{32'h8000_0000, 1'b0, 1'b0, 32'd0, 1'b0},
         '{32'h0000_0000, 1'b0, 1'b0, 32'd0, 1'b0},
         '{32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff, 1'b0},
         '{32'hffff_ffff, 1'b0, 1'b0, 32'd0, 1'b0},
         '{32'hffff_ffff, 1'b0, 1'b1, 32'hffff_ffff, 1'b0},   // duplicates
         '{32'h5555_5555, 1'b1, 1'b0, 32'd0, 1'b0},
         '{32'haaaa_aaaa, 1'b0, 1'b0, 32'd0, 1'b0},
         '{32'h0000_0001, 1'b0, 1'b0, 32'd0, 1'b0},
         '{32'h7fff_fffe, 1'b0, 1'b0, 32'd0, 1'b0},
         '{32'h8000_0001, 1'b0, 1'b0, 32'd0, 1'b0}
      };
      foreach (table_rows[i]) begin
         r = table_rows[i];
         n = words_queued;
         send_word(r.sample, r.first);
         if (r.chk && (words_queued != n + 1 ||
                       last_word.median !== r.med ||
                       last_word.overflow !== r.ovf)) begin
            $error("table row %0d median exp %0d got %0d", i, $signed(r.med),
                   $signed(last_word.median));
            errors++;
         end
      end

      // fill the store to capacity and beyond: overflow words
      send_word(rand_sample(), 1);
      for (k = 1; k < RMTH_CAPACITY + 3; k++) send_word(rand_sample(), 0);
      n = words_queued;
      send_word(32'd7, 0);
      if (last_word.overflow !== 1'b1 || words_queued != n + 1) begin
         $error("overflow exp 1 got %0b", last_word.overflow);
         errors++;
      end
      send_word(32'd7, 1);  // first clears a full store

      // random sequences, mostly short, with a quiet stretch in the middle
      n = 0;
      while (n < 600) begin
         quiet = (n > 250 && n < 350);
         len = ($urandom_range(9) == 0) ? $urandom_range(60) + 1 : $urandom_range(12) + 1;
         for (seq_len = 0; seq_len < len; seq_len++) begin
            send_word(rand_sample(), (seq_len == 0) && ($urandom_range(7) != 0));
            n++;
         end
      end
      quiet = 0;
      req_tvalid <= 0;

      while (medians_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+src
src/rmth_pkg.sv
src/rmth_ram.sv
src/rmth_ctrl.sv
src/rmth_dp.sv
src/running_median_two_heaps.sv
bench/tb_running_median_two_heaps.sv
